// ----- design/packbits_bitplane_row_decoder_unit_defines.svh -----
// Assertion macros used by the RTL of the packed row decoder.
`ifndef PACKBITS_BITPLANE_ROW_DECODER_UNIT_DEFINES_SVH
`define PACKBITS_BITPLANE_ROW_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle during reset.
`define PBRD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbrd: check failed");

// Next-cycle implication, sampled on clk_i, idle during reset.
`define PBRD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbrd: check failed");

`endif

// ----- design/pbrd_pkg.sv -----
package pbrd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_WRITE,
    ST_EOP,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_REP  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    CFG_FORMAT_MODE  = 3'd0,
    CFG_IMAGE_WIDTH  = 3'd1,
    CFG_IMAGE_HEIGHT = 3'd2,
    CFG_PLANE_COUNT  = 3'd3,
    CFG_HAS_MASK     = 3'd4
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned X_W        = 12;

  localparam logic           FUNC_READ = 1'b1;
  localparam logic [7:0]     CTRL_NOP  = 8'd128;
  localparam logic [X_W-1:0] X_CAP     = 12'hFFF;

  localparam logic [7:0] PLANE_BITS [8] = '{
    8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128
  };

  typedef struct packed {
    logic           planar;
    logic           first_plane;
    logic [7:0]     plane_bit;
    logic [X_W-1:0] x_pos;
    logic [X_W-1:0] width;
  } merge_ctl_t;

endpackage

// ----- design/pbrd_intf.sv -----
interface pbrd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  logic [7:0] read_index;

  modport source (output valid, output func, output data_byte, output read_index,
                  input ready);
  modport sink (input valid, input func, input data_byte, input read_index,
                output ready);
endinterface

interface pbrd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] pixel_group;
  logic        row_done;
  logic        image_done;
  logic [15:0] row_number;

  modport source (output valid, output pixel_group, output row_done, output image_done,
                  output row_number, input ready);
  modport sink (input valid, input pixel_group, input row_done, input image_done,
                input row_number, output ready);
endinterface

// ----- design/pbrd_line_store.sv -----
module pbrd_line_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [DEPTH];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pbrd_word_merge.sv -----
module pbrd_word_merge #(
  parameter int unsigned AW = 8
) (
  input  pbrd_pkg::merge_ctl_t ctl_i,
  input  logic [7:0]           data_i,
  input  logic [AW-1:0]        addr_i,
  input  logic [63:0]          old_i,
  output logic [63:0]          new_o
);

  always_comb begin
    logic [12:0] pos;
    logic [12:0] off;
    logic        hit;
    logic [7:0]  v;
    logic [7:0]  ob;
    new_o = old_i;
    for (int k = 0; k < 8; k++) begin
      pos = 13'({addr_i, 3'(k)});
      off = pos - {1'b0, ctl_i.x_pos};
      hit = (pos >= {1'b0, ctl_i.x_pos}) && (off < (ctl_i.planar ? 13'd8 : 13'd1)) &&
            (pos < {1'b0, ctl_i.width});
      ob  = old_i[8*k +: 8];
      // planar: bit 7 of the byte lands on the leftmost pixel
      if (ctl_i.planar) begin
        v = data_i[~off[2:0]] ? ctl_i.plane_bit : 8'd0;
      end else begin
        v = data_i;
      end
      if (hit) begin
        new_o[8*k +: 8] = (ctl_i.planar && !ctl_i.first_plane) ? (ob | v) : v;
      end
    end
  end

endmodule

// ----- design/packbits_bitplane_row_decoder_unit.sv -----
// A control byte passes ST_DONE before its word is published, a read ST_READ first.
// A data byte does an ST_EMIT/ST_WRITE read-modify-write per emitted pixel byte (a
// second ST_WRITE when a planar byte straddles two 8-pixel words of the line store),
// then wraps up through ST_EOP (after a packet's last byte) and ST_DONE. One byte is
// in work at a time; a repeat run is paced by the read-modify-write on the single
// line-store port pair. Reset inits decoder and config; the line store is not cleared.
`include "packbits_bitplane_row_decoder_unit_defines.svh"

module packbits_bitplane_row_decoder_unit #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_PLANES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pbrd_in_if.sink                            in_i,
  pbrd_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [pbrd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import pbrd_pkg::*;

  localparam int unsigned DEPTH = (MAX_WIDTH + 7) / 8;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [9:0]  DepthW = 10'(DEPTH);
  localparam logic [12:0] MaxW   = 13'(MAX_WIDTH);
  localparam logic [3:0]  MaxP   = 4'(MAX_PLANES);

  // configuration
  logic        format_mode_q;
  logic [11:0] image_width_q;
  logic [15:0] image_height_q;
  logic [3:0]  plane_count_q;
  logic        has_mask_q;

  // decoder state
  state_e      state_q, state_d;
  phase_e      phase_q;
  logic [7:0]  count_left_q;
  logic [11:0] x_q;
  logic [3:0]  plane_q;
  logic        mask_q;
  logic [15:0] row_counter_q;
  logic        row_full_q;
  logic [7:0]  emit_cnt_q;
  logic        eop_pend_q;
  logic        sub_q;
  logic        out_valid_q;

  // payload
  logic [AW-1:0] cur_addr_q;
  logic [7:0]    data_q;
  logic          read_ok_q;
  logic [63:0]   res_group_q;
  logic          res_done_q;
  logic          res_img_q;
  logic [63:0]   out_group_q;
  logic          out_done_q;
  logic          out_img_q;
  logic [15:0]   out_row_q;

  logic [11:0] eff_w;
  logic [3:0]  eff_p;
  logic [15:0] eff_h;
  logic        accept;
  logic        feed;
  logic        out_free;
  logic        emit_writes;
  logic        need_second;
  logic        emit_finish;
  logic [12:0] next_base;
  logic [12:0] x_sum;
  logic [11:0] x_adv;
  logic [16:0] row_cnt_inc;
  logic        x_ge_w;
  logic        plane_more;
  logic        eop_done;
  logic [3:0]  eop_plane;
  logic        eop_mask;
  state_e      emit_next;

  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   mem_rdata;
  logic [63:0]   merged;
  merge_ctl_t    merge_ctl;

  assign eff_w = (image_width_q == 12'd0) ? 12'd1 :
                 ({1'b0, image_width_q} > MaxW) ? 12'(MAX_WIDTH) : image_width_q;
  assign eff_p = (plane_count_q == 4'd0) ? 4'd1 :
                 (plane_count_q > MaxP) ? MaxP : plane_count_q;
  assign eff_h = (image_height_q == 16'd0) ? 16'd1 : image_height_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign feed       = accept && (in_i.func != FUNC_READ);
  assign out_free   = !out_valid_q || out_o.ready;

  assign emit_writes = (x_q < eff_w) && !(format_mode_q && mask_q);
  assign next_base   = {1'b0, x_q[11:3], 3'b000} + 13'd8;
  assign need_second = !sub_q && format_mode_q && (x_q[2:0] != 3'd0) &&
                       (next_base < {1'b0, eff_w});
  assign emit_finish = ((state_q == ST_EMIT) && !emit_writes) ||
                       ((state_q == ST_WRITE) && !need_second);
  assign emit_next   = (emit_cnt_q == 8'd1) ? (eop_pend_q ? ST_EOP : ST_DONE) : ST_EMIT;

  assign x_sum = {1'b0, x_q} + (format_mode_q ? 13'd8 : 13'd1);
  assign x_adv = (x_sum > {1'b0, X_CAP}) ? X_CAP : x_sum[11:0];

  assign row_cnt_inc = {1'b0, row_counter_q} + 17'd1;

  // end of packet with the pass filled: step plane, enter mask plane, or close the row
  assign x_ge_w     = (x_q >= eff_w);
  assign plane_more = (({1'b0, plane_q} + 5'd1) < {1'b0, eff_p});
  always_comb begin
    eop_done  = 1'b0;
    eop_plane = plane_q;
    eop_mask  = mask_q;
    if (x_ge_w) begin
      if (format_mode_q && !mask_q && plane_more) begin
        eop_plane = plane_q + 4'd1;
      end else if (format_mode_q && !mask_q && has_mask_q) begin
        eop_plane = 4'd0;
        eop_mask  = 1'b1;
      end else begin
        eop_done  = 1'b1;
        eop_plane = 4'd0;
        eop_mask  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = cur_addr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.func == FUNC_READ) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(in_i.read_index);
            state_d   = ST_READ;
          end else begin
            unique case (phase_q)
              PH_LIT, PH_REP: state_d = ST_EMIT;
              default:        state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_EMIT: begin
        if (emit_writes) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(x_q[11:3]);
          state_d   = ST_WRITE;
        end else begin
          state_d = emit_next;
        end
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        if (need_second) begin
          mem_re    = 1'b1;
          mem_raddr = cur_addr_q + AW'(1);
        end else begin
          state_d = emit_next;
        end
      end
      ST_EOP: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_mode_q  <= 1'b0;
      image_width_q  <= 12'd320;
      image_height_q <= 16'd200;
      plane_count_q  <= 4'd8;
      has_mask_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FORMAT_MODE:  format_mode_q  <= cfg_data_i[0];
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[11:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[15:0];
        CFG_PLANE_COUNT:  plane_count_q  <= cfg_data_i[3:0];
        CFG_HAS_MASK:     has_mask_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_CTRL;
      count_left_q  <= 8'd0;
      x_q           <= 12'd0;
      plane_q       <= 4'd0;
      mask_q        <= 1'b0;
      row_counter_q <= 16'd0;
      row_full_q    <= 1'b0;
      emit_cnt_q    <= 8'd0;
      eop_pend_q    <= 1'b0;
      sub_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (feed) begin
        // first byte after a finished row opens the next row
        if (row_full_q) begin
          row_full_q    <= 1'b0;
          row_counter_q <= (row_cnt_inc >= {1'b0, eff_h}) ? 16'd0 : row_cnt_inc[15:0];
        end
        unique case (phase_q)
          PH_LIT: begin
            emit_cnt_q <= 8'd1;
            if (count_left_q == 8'd0) begin
              phase_q    <= PH_CTRL;
              eop_pend_q <= 1'b1;
            end else begin
              count_left_q <= count_left_q - 8'd1;
              eop_pend_q   <= 1'b0;
            end
          end
          PH_REP: begin
            emit_cnt_q   <= count_left_q + 8'd1;
            count_left_q <= 8'd0;
            phase_q      <= PH_CTRL;
            eop_pend_q   <= 1'b1;
          end
          default: begin
            if (in_i.data_byte < CTRL_NOP) begin
              phase_q      <= PH_LIT;
              count_left_q <= in_i.data_byte;
            end else if (in_i.data_byte > CTRL_NOP) begin
              phase_q      <= PH_REP;
              count_left_q <= 8'(9'd256 - {1'b0, in_i.data_byte});
            end else begin
              phase_q <= PH_CTRL;
            end
          end
        endcase
      end
      if (emit_finish) begin
        x_q        <= x_adv;
        emit_cnt_q <= emit_cnt_q - 8'd1;
      end
      if (state_q == ST_EMIT) begin
        sub_q <= 1'b0;
      end else if ((state_q == ST_WRITE) && need_second) begin
        sub_q <= 1'b1;
      end
      if ((state_q == ST_EOP) && x_ge_w) begin
        x_q     <= 12'd0;
        plane_q <= eop_plane;
        mask_q  <= eop_mask;
        if (eop_done) begin
          row_full_q <= 1'b1;
        end
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q      <= in_i.data_byte;
      read_ok_q   <= ({2'b00, in_i.read_index} < DepthW);
      res_group_q <= 64'd0;
      res_done_q  <= 1'b0;
      res_img_q   <= 1'b0;
    end
    if (state_q == ST_READ) begin
      res_group_q <= read_ok_q ? mem_rdata : 64'd0;
    end
    if (state_q == ST_EMIT) begin
      cur_addr_q <= AW'(x_q[11:3]);
    end else if ((state_q == ST_WRITE) && need_second) begin
      cur_addr_q <= cur_addr_q + AW'(1);
    end
    if (state_q == ST_EOP) begin
      res_done_q <= eop_done;
      res_img_q  <= eop_done && (row_cnt_inc >= {1'b0, eff_h});
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_group_q <= res_group_q;
      out_done_q  <= res_done_q;
      out_img_q   <= res_img_q;
      out_row_q   <= row_counter_q;
    end
  end

  assign merge_ctl.planar      = format_mode_q;
  assign merge_ctl.first_plane = (plane_q == 4'd0);
  assign merge_ctl.plane_bit   = PLANE_BITS[plane_q[2:0]];
  assign merge_ctl.x_pos       = x_q;
  assign merge_ctl.width       = eff_w;

  pbrd_word_merge #(
    .AW(AW)
  ) u_merge (
    .ctl_i  (merge_ctl),
    .data_i (data_q),
    .addr_i (cur_addr_q),
    .old_i  (mem_rdata),
    .new_o  (merged)
  );

  pbrd_line_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cur_addr_q),
    .wdata_i (merged),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_group = out_group_q;
  assign out_o.row_done    = out_done_q;
  assign out_o.image_done  = out_img_q;
  assign out_o.row_number  = out_row_q;

  `PBRD_ASSERT_IMPL(a_write_in_row, mem_we, (x_q < eff_w) && !(format_mode_q && mask_q))
  `PBRD_ASSERT_IMPL(a_emit_count, (state_q == ST_EMIT) || (state_q == ST_WRITE), emit_cnt_q != 8'd0)
  `PBRD_ASSERT_IMPL(a_second_word, sub_q && (state_q == ST_WRITE), format_mode_q && (x_q[2:0] != 3'd0))
  `PBRD_ASSERT_NEXT(a_publish, (state_q == ST_DONE) && out_free, out_valid_q && (state_q == ST_IDLE))

endmodule

// ----- tb/packbits_bitplane_row_decoder_unit_test.sv -----
`timescale 1ns / 100ps

module packbits_bitplane_row_decoder_unit_test;
  import pbrd_pkg::*;

  localparam int unsigned MAX_W       = 2048;
  localparam int unsigned ITEMS       = 1500;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned IDLE_PCT    = 28;

  localparam logic       FUNC_FEED    = ~FUNC_READ;
  localparam logic [7:0] CTRL_LIT_MIN = 8'd0;    // one literal byte
  localparam logic [7:0] CTRL_LIT_MAX = 8'd127;  // 128 literal bytes
  localparam logic [7:0] CTRL_REP_MAX = 8'd129;  // repeat 128 times
  localparam logic [7:0] CTRL_REP_MIN = 8'd255;  // repeat twice

  class row_decode_checker;
    typedef struct packed {
      logic [63:0] pixel_group;
      logic        row_done;
      logic        image_done;
      logic [15:0] row_number;
    } result_word_t;

    result_word_t expected_q[$];

    logic        fmt_planar;
    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [3:0]  planes_reg;
    logic        has_mask_reg;

    phase_e      phase;
    logic [7:0]  run_left;
    int unsigned x_pos;
    logic [3:0]  plane_idx;
    logic        in_mask;
    logic [15:0] row_ctr;
    logic        row_full;
    logic [7:0]  line_px [MAX_W];
    bit          px_written [MAX_W];

    int unsigned errors, results, rows, pictures, reads;

    function new();
      fmt_planar   = 1'b0;
      width_reg    = 12'd320;
      height_reg   = 16'd200;
      planes_reg   = 4'd8;
      has_mask_reg = 1'b0;
      phase        = PH_CTRL;
      run_left     = '0;
      x_pos        = 0;
      plane_idx    = '0;
      in_mask      = 1'b0;
      row_ctr      = '0;
      row_full     = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] val);
      case (idx)
        CFG_FORMAT_MODE:  fmt_planar   = val[0];
        CFG_IMAGE_WIDTH:  width_reg    = val[11:0];
        CFG_IMAGE_HEIGHT: height_reg   = val;
        CFG_PLANE_COUNT:  planes_reg   = val[3:0];
        CFG_HAS_MASK:     has_mask_reg = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_planes();
      if (planes_reg == 0) return 1;
      if (planes_reg > 8) return 8;
      return planes_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function void put_byte(logic [7:0] b);
      int unsigned w, pos, step;
      logic [7:0]  bit_v, v;
      w = eff_width();
      step = fmt_planar ? 8 : 1;
      if (!fmt_planar) begin
        if (x_pos < w) begin
          line_px[x_pos]    = b;
          px_written[x_pos] = 1'b1;
        end
      end else if (!in_mask) begin
        bit_v = 8'd1 << plane_idx[2:0];
        for (int unsigned k = 0; k < 8; k++) begin
          pos = x_pos + k;
          v   = b[7-k] ? bit_v : 8'd0;
          if (pos < w) begin
            // plane 0 overwrites, later planes merge in
            if (plane_idx == 0) begin
              line_px[pos]    = v;
              px_written[pos] = 1'b1;
            end else begin
              line_px[pos] = line_px[pos] | v;
            end
          end
        end
      end
      x_pos = (x_pos + step > X_CAP) ? X_CAP : x_pos + step;
    endfunction

    function bit close_packet();
      if (x_pos < eff_width()) return 1'b0;
      x_pos = 0;
      if (fmt_planar && !in_mask) begin
        if (plane_idx + 1 < eff_planes()) begin
          plane_idx++;
          return 1'b0;
        end
        plane_idx = '0;
        if (has_mask_reg) begin
          in_mask = 1'b1;
          return 1'b0;
        end
      end
      plane_idx = '0;
      in_mask   = 1'b0;
      row_full  = 1'b1;
      return 1'b1;
    endfunction

    function void note_input(logic func, logic [7:0] data, logic [7:0] ridx);
      result_word_t w;
      int unsigned  pos;
      bit           done;
      w    = '0;
      done = 1'b0;
      if (func == FUNC_READ) begin
        for (int unsigned k = 0; k < 8; k++) begin
          pos = int'(ridx) * 8 + k;
          if (pos < MAX_W) w.pixel_group[8*k +: 8] = line_px[pos];
        end
        w.row_number = row_ctr;
        reads++;
        expected_q.push_back(w);
        return;
      end
      // the first byte after a finished row moves to the next row
      if (row_full) begin
        row_full = 1'b0;
        row_ctr  = (int'(row_ctr) + 1 >= eff_height()) ? 16'd0 : row_ctr + 16'd1;
      end
      case (phase)
        PH_LIT: begin
          put_byte(data);
          if (run_left == 0) begin
            phase = PH_CTRL;
            done  = close_packet();
          end else begin
            run_left--;
          end
        end
        PH_REP: begin
          for (int unsigned k = 0; k <= run_left; k++) put_byte(data);
          run_left = '0;
          phase    = PH_CTRL;
          done     = close_packet();
        end
        default: begin
          phase = PH_CTRL;
          if (data < CTRL_NOP) begin
            phase    = PH_LIT;
            run_left = data;
          end else if (data > CTRL_NOP) begin
            phase    = PH_REP;
            run_left = 8'(256 - int'(data));
          end
        end
      endcase
      w.row_done   = done;
      w.image_done = done && (int'(row_ctr) + 1 >= eff_height());
      w.row_number = row_ctr;
      if (w.row_done) rows++;
      if (w.image_done) pictures++;
      expected_q.push_back(w);
    endfunction

    function bit group_ready(int unsigned g);
      for (int unsigned k = 0; k < 8; k++) begin
        if (!px_written[g*8 + k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // only groups whose pixels were all written may be read
    function int pick_group();
      int g;
      repeat (8) begin
        g = $urandom_range(255);
        if (group_ready(g)) return g;
      end
      return -1;
    endfunction

    function void check_result(logic [63:0] group, logic rdone, logic idone,
                               logic [15:0] rnum);
      result_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got group %h row_done %b image_done %b row %0d",
                 $time, group, rdone, idone, rnum);
        return;
      end
      want = expected_q.pop_front();
      results++;
      if (group !== want.pixel_group) begin
        errors++;
        $display("%0t: pixel_group expected %h got %h", $time, want.pixel_group, group);
      end
      if (rdone !== want.row_done) begin
        errors++;
        $display("%0t: row_done expected %b got %b", $time, want.row_done, rdone);
      end
      if (idone !== want.image_done) begin
        errors++;
        $display("%0t: image_done expected %b got %b", $time, want.image_done, idone);
      end
      if (rnum !== want.row_number) begin
        errors++;
        $display("%0t: row_number expected %0d got %0d", $time, want.row_number, rnum);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pbrd_in_if  in_if ();
  pbrd_out_if out_if ();

  packbits_bitplane_row_decoder_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  row_decode_checker board = new();

  bit          steady;
  int unsigned words_sent, phase_words, settings, stall_cycles;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_result(out_if.pixel_group, out_if.row_done, out_if.image_done,
                         out_if.row_number);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL packbits_bitplane_row_decoder_unit");
      $finish;
    end
  end

  task automatic send_word(logic func, logic [7:0] data, logic [7:0] ridx);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= func;
    in_if.data_byte  <= data;
    in_if.read_index <= ridx;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_input(func, data, ridx);
    words_sent++;
    phase_words++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(FUNC_FEED, b, 8'($urandom_range(255)));
  endtask

  task automatic send_read();
    int g;
    g = board.pick_group();
    if (g >= 0) send_word(FUNC_READ, 8'($urandom_range(255)), 8'(g));
  endtask

  // hold off until every word due has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [15:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    board.set_reg(r, v);
  endtask

  task automatic configure(logic planar, logic [11:0] w, logic [15:0] h, logic [3:0] pl,
                           logic m);
    write_reg(CFG_FORMAT_MODE, {15'd0, planar});
    write_reg(CFG_IMAGE_WIDTH, {4'd0, w});
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_PLANE_COUNT, {12'd0, pl});
    write_reg(CFG_HAS_MASK, {15'd0, m});
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // one well-formed row: every plane pass (and the mask, in planar mode with a mask) filled by packets
  task automatic send_row(bit lead_long);
    int unsigned passes, need, left, n;
    bit          lit;
    passes = board.fmt_planar ? board.eff_planes() + board.has_mask_reg : 1;
    need   = board.fmt_planar ? (board.eff_width() + 7) / 8 : board.eff_width();
    for (int unsigned k = 0; k < passes; k++) begin
      left = need;
      while (left > 0) begin
        if ($urandom_range(3) == 0) send_read();
        if ($urandom_range(19) == 0) send_byte(CTRL_NOP);
        lit = ($urandom_range(2) == 0);
        if (lead_long) begin
          n         = 128;
          lit       = 1'b1;
          lead_long = 1'b0;
        end else if ($urandom_range(9) == 0) begin
          n = $urandom_range(128, 1);
        end else if (lit) begin
          n = $urandom_range(left < 16 ? left : 16, 1);
        end else begin
          n = $urandom_range(left < 128 ? left : 128, 1);
        end
        if (n == 1) lit = 1'b1;
        if (lit) begin
          send_byte(8'(n - 1));
          repeat (n) begin
            if ($urandom_range(15) == 0) send_read();
            send_byte(8'($urandom_range(255)));
          end
        end else begin
          send_byte(8'(257 - n));
          send_byte(8'($urandom_range(255)));
        end
        left = (n >= left) ? 0 : left - n;
      end
    end
  endtask

  task automatic send_noise(int unsigned count);
    repeat (count) begin
      if ($urandom_range(3) == 0) send_read();
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned p, rows_in_phase;
    logic [11:0] w;
    logic [15:0] h;
    logic [3:0]  pl;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.func   = FUNC_FEED;
    in_if.data_byte  = '0;
    in_if.read_index = '0;
    out_if.ready = 1'b0;
    steady       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: chunky, 320 wide; one row from the run extremes, reads, a partial row, reads
    send_byte(CTRL_NOP);
    send_byte(CTRL_REP_MAX);
    send_byte(8'hFF);
    send_byte(CTRL_REP_MIN);
    send_byte(8'hA5);
    send_byte(CTRL_LIT_MIN);
    send_byte(8'h00);
    send_byte(CTRL_REP_MAX);
    send_byte(8'h5A);
    send_byte(8'(257 - 62));
    send_byte(8'h3C);
    send_word(FUNC_READ, 8'hFF, 8'd0);
    send_word(FUNC_READ, 8'h00, 8'd39);
    send_word(FUNC_READ, 8'h5A, 8'd16);
    send_byte(CTRL_NOP);
    send_byte(CTRL_LIT_MIN);
    send_byte(8'hFF);
    send_byte(8'(257 - 57));
    send_byte(8'h81);
    send_word(FUNC_READ, 8'h00, 8'd0);
    send_word(FUNC_READ, 8'hFF, 8'd7);
    drain();

    words_sent = 0;
    p = 0;
    while (words_sent < ITEMS) begin
      case (p)
        0: configure(1'b0, 12'd2048, 16'd2, 4'd8, 1'b0);
        1: configure(1'b1, 12'd1, 16'd1, 4'd1, 1'b0);
        2: configure(1'b1, 12'd2048, 16'd65535, 4'd8, 1'b1);
        3: configure(1'b1, 12'd0, 16'd0, 4'd0, 1'b1);
        4: configure(1'b0, 12'd4095, 16'd3, 4'd15, 1'b1);
        default: begin
          case ($urandom_range(9))
            0: w = 12'd1;
            1: w = 12'd8;
            2: w = 12'd9;
            3: w = 12'($urandom_range(2048, 1));
            default: w = 12'($urandom_range(64, 1));
          endcase
          case ($urandom_range(4))
            0: h = 16'd1;
            1: h = 16'd65535;
            default: h = 16'($urandom_range(4, 1));
          endcase
          case ($urandom_range(7))
            0: pl = 4'd0;
            1: pl = 4'd15;
            default: pl = 4'($urandom_range(8, 1));
          endcase
          configure(1'($urandom_range(1)), w, h, pl, 1'($urandom_range(1)));
        end
      endcase
      steady        = (p == 5);
      phase_words   = 0;
      rows_in_phase = 0;
      do begin
        if (p >= 4 && $urandom_range(4) == 0) send_noise($urandom_range(12, 2));
        send_row(p == 0 && rows_in_phase == 0);
        rows_in_phase++;
        if (p == 6 && rows_in_phase == 1) drain();
      end while (phase_words < 100 && words_sent < ITEMS);
      repeat (3) send_read();
      drain();
      p++;
    end

    drain();
    repeat (16) @(posedge clk_i);
    $display("covered %0d group reads and %0d rows (%0d full pictures) over %0d settings",
             board.reads, board.rows, board.pictures, settings);
    $display("checked %0d result words", board.results);
    if (board.errors == 0) begin
      $display("PASS packbits_bitplane_row_decoder_unit");
    end else begin
      $display("FAIL packbits_bitplane_row_decoder_unit");
    end
    $finish;
  end

endmodule
